/* design/bfm_pkg.sv */
// shared types, register codes and the divide-by-nine digit step of the box filter
package bfm_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int ROWS_W      = 16;
  localparam int COLS_W      = 11;
  localparam int STEP_W      = 8;
  localparam int MEAN_W      = 32;
  localparam int OROW_W      = 16;
  localparam int OCOL_W      = 10;
  localparam int OUT_TDATA_W = 64;

  // m_tdata layout
  localparam int MEAN_LSB = 0;
  localparam int ROW_LSB  = MEAN_LSB + MEAN_W;
  localparam int COL_LSB  = ROW_LSB + OROW_W;
  localparam int PAD_W    = OUT_TDATA_W - COL_LSB - OCOL_W;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_STEP = 2'd2;

  localparam logic [ROWS_W-1:0] ROWS_RST = 16'd3;
  localparam logic [COLS_W-1:0] COLS_RST = 11'd3;
  localparam logic [STEP_W-1:0] STEP_RST = 8'd1;

  typedef struct packed {
    logic [OROW_W-1:0] row;
    logic [OCOL_W-1:0] col;
    logic              last;
  } meta_t;

  // one radix-16 digit of a divide by nine: v = {remainder, digit}, v < 144
  // returns {quotient digit, new remainder}
  function automatic logic [7:0] div9_step(input logic [7:0] v);
    logic [13:0] p;
    logic [3:0]  q;
    logic [7:0]  r;
    p = 14'(v) * 14'd57;
    q = p[12:9];
    r = v - 8'(q) * 8'd9;
    return {q, r[3:0]};
  endfunction

endpackage

/* design/bfm_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module bfm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/box_filter_3x3_mean.sv */
// 3x3 box mean filter: line store, column sums and a pipelined divide by nine
//
// Samples enter in raster order on s_tvalid/s_tready/s_tdata, one word per
// cycle while s_tready is high. For each selected interior point the block
// sends one word on m_tvalid/m_tready/m_tdata (mean, centre row, centre
// column) with m_tlast marking the final result of a frame. Samples that
// complete no selected window produce nothing.
// Registers are written on the cfg channel (cfg_ready is always high): index 0
// rows, 1 columns, 2 step. Write them only while the block is idle; the block
// itself does not enforce it.
// Throughput: one sample per cycle unless stalled, set by the single line store
// ram read when a sample is taken and written back as it leaves the first stage.
// A result passes the line store read, column sum, abs, one radix-16
// divide-by-nine digit per stage, sign and output register before it shows on
// m_tvalid. When m_tready is low, results pile up in the divide stages;
// s_tready only drops once a result-bearing sample can no longer enter them.
// Reset sets rows 3, columns 3, step 1 and clears counters and phases; the
// line store is not cleared and the first frame fills it before use.
module box_filter_3x3_mean #(
  parameter int MAX_COLS    = 1024,
  parameter int GROUP_WIDTH = 8,
  parameter int SAMPLE_BITS = 32,
  localparam int IN_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [IN_TDATA_W-1:0]              s_tdata,   // sample
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bfm_pkg::OUT_TDATA_W-1:0]    m_tdata,   // mean_value, out_row, out_col
  output logic                               m_tlast,   // frame_last
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(MAX_COLS);
  localparam int CLW   = $clog2(MAX_COLS + 1);
  localparam int CXW   = (CLW > bfm_pkg::COLS_W) ? CLW : bfm_pkg::COLS_W;
  localparam int PMAX  = GROUP_WIDTH * 255;
  localparam int PW    = $clog2(PMAX + 1);
  localparam int NXW   = $clog2(MAX_COLS + PMAX + 1);
  localparam int MAGW  = SB + 3;
  localparam int NDIG  = (MAGW + 3) / 4;
  localparam int NUMW  = 4 * NDIG;
  localparam int EXTW  = (SB + 1 > bfm_pkg::MEAN_W) ? SB + 1 : bfm_pkg::MEAN_W;

  // configuration
  logic [bfm_pkg::ROWS_W-1:0] num_rows;
  logic [bfm_pkg::COLS_W-1:0] num_cols;
  logic [bfm_pkg::STEP_W-1:0] skip_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows  <= bfm_pkg::ROWS_RST;
      num_cols  <= bfm_pkg::COLS_RST;
      skip_step <= bfm_pkg::STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bfm_pkg::REG_NUM_ROWS:  num_rows  <= cfg_data[bfm_pkg::ROWS_W-1:0];
        bfm_pkg::REG_NUM_COLS:  num_cols  <= cfg_data[bfm_pkg::COLS_W-1:0];
        bfm_pkg::REG_SKIP_STEP: skip_step <= cfg_data[bfm_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [bfm_pkg::ROWS_W-1:0] rows_eff;
  logic [CXW-1:0]             cols_ext;
  logic [CXW-1:0]             cols_eff;
  logic [CXW-1:0]             cols_m1;
  logic [bfm_pkg::STEP_W-1:0] step_eff;
  logic [PW-1:0]              period;

  always_comb begin
    rows_eff = (num_rows < 16'd3) ? 16'd3 : num_rows;
    cols_ext = CXW'(num_cols);
    if (cols_ext < CXW'(3)) begin
      cols_eff = CXW'(3);
    end else if (cols_ext > CXW'(MAX_COLS)) begin
      cols_eff = CXW'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
    cols_m1  = cols_eff - CXW'(1);
    step_eff = (skip_step == '0) ? 8'd1 : skip_step;
    period   = PW'(GROUP_WIDTH) * PW'(step_eff);
  end

  // position and phase of the next sample
  logic [bfm_pkg::ROWS_W-1:0] row_count;
  logic [AW-1:0]              col_count;
  logic [bfm_pkg::STEP_W-1:0] row_phase;
  logic [PW-1:0]              col_phase;

  logic        in_go;
  logic        f1_go;
  logic        f1_v;
  logic [CXW-1:0] c_inc;
  logic [bfm_pkg::ROWS_W:0] r_inc;
  logic [PW:0] cp_inc;
  logic [PW-1:0] cp_adv;
  logic [bfm_pkg::STEP_W:0] rp_inc;
  logic [bfm_pkg::STEP_W-1:0] rp_adv;
  logic        row_end;
  logic        frame_end;
  logic        emit;
  logic [bfm_pkg::ROWS_W-1:0] ctr_i;
  logic [AW-1:0] ctr_j;
  logic [NXW-1:0] next_j;
  logic        last_row;
  logic        last_col;

  assign s_tready = !f1_v || f1_go;
  assign in_go    = s_tvalid && s_tready;

  always_comb begin
    c_inc     = CXW'(col_count) + CXW'(1);
    row_end   = c_inc >= cols_eff;
    r_inc     = {1'b0, row_count} + 17'd1;
    frame_end = r_inc >= {1'b0, rows_eff};
    cp_inc    = {1'b0, col_phase} + (PW + 1)'(1);
    cp_adv    = (cp_inc >= {1'b0, period}) ? '0 : cp_inc[PW-1:0];
    rp_inc    = {1'b0, row_phase} + 9'd1;
    rp_adv    = (rp_inc >= {1'b0, step_eff}) ? '0 : rp_inc[bfm_pkg::STEP_W-1:0];
    emit      = (row_count >= 16'd2) && (col_count >= AW'(2)) && (row_phase == '0)
                && (col_phase < PW'(GROUP_WIDTH));
    ctr_i     = row_count - 16'd1;
    ctr_j     = col_count - AW'(1);
    // column of the next selected centre in this row
    if (cp_inc < (PW + 1)'(GROUP_WIDTH)) begin
      next_j = NXW'(ctr_j) + NXW'(1);
    end else begin
      next_j = NXW'(ctr_j) + NXW'(period) - NXW'(col_phase);
    end
    last_row  = ({1'b0, ctr_i} + 17'(step_eff)) > ({1'b0, rows_eff} - 17'd2);
    last_col  = next_j >= NXW'(cols_m1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      row_phase <= '0;
      col_phase <= '0;
    end else if (in_go) begin
      if (row_end) begin
        col_count <= '0;
        col_phase <= '0;
        if (frame_end) begin
          row_count <= '0;
          row_phase <= '0;
        end else begin
          row_count <= r_inc[bfm_pkg::ROWS_W-1:0];
          row_phase <= (r_inc <= 17'd2) ? '0 : rp_adv;
        end
      end else begin
        col_count <= AW'(c_inc);
        if (col_count >= AW'(2)) begin
          col_phase <= cp_adv;
        end
      end
    end
  end

  // line store: entry c holds {row above previous, previous row} at column c
  logic [2*SB-1:0] rd_data;
  logic [SB-1:0]   f1_x;
  logic [AW-1:0]   f1_addr;
  logic            f1_emit;
  bfm_pkg::meta_t  f1_meta;
  logic            d0_ready;

  bfm_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (f1_go),
    .wr_addr (f1_addr),
    .wr_data ({rd_data[SB-1:0], f1_x}),
    .rd_en   (in_go),
    .rd_addr (col_count),
    .rd_data (rd_data)
  );

  assign f1_go = f1_v && (!f1_emit || d0_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (s_tready) begin
      f1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      f1_x         <= s_tdata[SB-1:0];
      f1_addr      <= col_count;
      f1_emit      <= emit;
      f1_meta.row  <= ctr_i;
      f1_meta.col  <= bfm_pkg::OCOL_W'(ctr_j);
      f1_meta.last <= last_row && last_col;
    end
  end

  // column sums of the two previous columns of the band
  logic signed [SB-1:0] top_s, mid_s, x_s;
  logic signed [SB+1:0] col3;
  logic signed [SB+1:0] cs1;
  logic signed [SB+2:0] pair;

  assign top_s = rd_data[2*SB-1:SB];
  assign mid_s = rd_data[SB-1:0];
  assign x_s   = f1_x;
  assign col3  = (SB + 2)'(top_s) + (SB + 2)'(mid_s) + (SB + 2)'(x_s);

  always_ff @(posedge clk) begin
    if (f1_go) begin
      cs1  <= col3;
      pair <= (SB + 3)'(cs1) + (SB + 3)'(col3);
    end
  end

  // divide pipeline, each stage moves on when the next one has room
  logic                 d0_v;
  logic signed [SB+2:0] d0_pair;
  logic signed [SB+1:0] d0_col3;
  bfm_pkg::meta_t       d0_meta;
  logic                 ab_v;
  logic                 ab_ready;
  logic signed [SB+3:0] ab_sum;
  bfm_pkg::meta_t       ab_meta;
  logic                 dg_v     [NDIG];
  logic                 dg_ready [NDIG];
  logic [NUMW-1:0]      dg_num   [NDIG];
  logic [3:0]           dg_rem   [NDIG];
  logic                 dg_neg   [NDIG];
  bfm_pkg::meta_t       dg_meta  [NDIG];
  logic                 out_v;
  logic                 out_ready;

  always_comb begin
    out_ready = !out_v || m_tready;
    dg_ready[NDIG-1] = !dg_v[NDIG-1] || out_ready;
    for (int k = NDIG - 2; k >= 0; k--) begin
      dg_ready[k] = !dg_v[k] || dg_ready[k+1];
    end
    ab_ready = !ab_v || dg_ready[0];
    d0_ready = !d0_v || ab_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d0_v <= 1'b0;
    end else if (d0_ready) begin
      d0_v <= f1_v && f1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (d0_ready && f1_v && f1_emit) begin
      d0_pair <= pair;
      d0_col3 <= col3;
      d0_meta <= f1_meta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ab_v <= 1'b0;
    end else if (ab_ready) begin
      ab_v <= d0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ab_ready && d0_v) begin
      ab_sum  <= (SB + 4)'(d0_pair) + (SB + 4)'(d0_col3);
      ab_meta <= d0_meta;
    end
  end

  logic signed [SB+3:0] ab_mag;
  assign ab_mag = ab_sum[SB+3] ? -ab_sum : ab_sum;

  for (genvar k = 0; k < NDIG; k++) begin : g_dig
    logic            v_in;
    logic [NUMW-1:0] num_in;
    logic [3:0]      rem_in;
    logic            neg_in;
    bfm_pkg::meta_t  meta_in;
    logic [7:0]      qr;
    logic            v_r;
    logic [NUMW-1:0] num_r;
    logic [3:0]      rem_r;
    logic            neg_r;
    bfm_pkg::meta_t  meta_r;

    if (k == 0) begin : g_first
      assign v_in    = ab_v;
      assign num_in  = NUMW'(ab_mag[SB+2:0]);
      assign rem_in  = 4'd0;
      assign neg_in  = ab_sum[SB+3];
      assign meta_in = ab_meta;
    end else begin : g_next
      assign v_in    = dg_v[k-1];
      assign num_in  = dg_num[k-1];
      assign rem_in  = dg_rem[k-1];
      assign neg_in  = dg_neg[k-1];
      assign meta_in = dg_meta[k-1];
    end

    assign qr = bfm_pkg::div9_step({rem_in, num_in[NUMW-1 -: 4]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (dg_ready[k]) begin
        v_r <= v_in;
      end
    end

    // dividend digits shift out at the top, quotient digits shift in below
    always_ff @(posedge clk) begin
      if (dg_ready[k] && v_in) begin
        num_r  <= {num_in[NUMW-5:0], qr[7:4]};
        rem_r  <= qr[3:0];
        neg_r  <= neg_in;
        meta_r <= meta_in;
      end
    end

    assign dg_v[k]    = v_r;
    assign dg_num[k]  = num_r;
    assign dg_rem[k]  = rem_r;
    assign dg_neg[k]  = neg_r;
    assign dg_meta[k] = meta_r;
  end

  // restore the sign, truncation toward zero follows from dividing the magnitude
  logic signed [SB:0]     quo_s;
  logic signed [SB:0]     mean_s;
  logic signed [EXTW-1:0] mean_ext;
  logic [bfm_pkg::MEAN_W-1:0] out_mean;
  bfm_pkg::meta_t         out_meta;

  assign quo_s    = {1'b0, dg_num[NDIG-1][SB-1:0]};
  assign mean_s   = dg_neg[NDIG-1] ? -quo_s : quo_s;
  assign mean_ext = EXTW'(mean_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_ready) begin
      out_v <= dg_v[NDIG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && dg_v[NDIG-1]) begin
      out_mean <= mean_ext[bfm_pkg::MEAN_W-1:0];
      out_meta <= dg_meta[NDIG-1];
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {{bfm_pkg::PAD_W{1'b0}}, out_meta.col, out_meta.row, out_mean};
  assign m_tlast  = out_meta.last;

endmodule

/* design/bfm_checker.sv */
// port-level checks on the box filter output channel, bound to the top level
module bfm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bfm_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tlast
);

  // a held result keeps its valid
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  // a held result keeps its word and frame mark
  a_word_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // only centres off the first row and first column are ever reported
  a_interior: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      (m_tdata[bfm_pkg::ROW_LSB +: bfm_pkg::OROW_W] != '0) &&
      (m_tdata[bfm_pkg::COL_LSB +: bfm_pkg::OCOL_W] != '0))
    else $error("result for a border point");

  // reset empties the result pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present right after reset");

endmodule

bind box_filter_3x3_mean bfm_checker u_bfm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
